// ===== hw/rtl/mbq_pkg.sv =====
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types, constants and the rounding function of the multichannel
// biquad cascade: item codes, controller states, command and status structs.
// ----------------------------------------------------------------------------
package mbq_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 24;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam int FRAC_SHIFT = 22;
   localparam int Q_W        = ACC_W - FRAC_SHIFT;
   localparam int DLY_W      = 4 * SAMPLE_W;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_COEF   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      SEL_B0 = 2'd0,
      SEL_A1 = 2'd1,
      SEL_A2 = 2'd2
   } coef_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_ACC,
      ST_WB,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      TERM_B0X,
      TERM_B0X2,
      TERM_A1Y1,
      TERM_A2Y2
   } term_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       clr_step;
      logic       take;
      term_type   term;
      acc_op_type acc_op;
      logic       wb;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_coef;
      logic ch_ok;
      logic bypass;
      logic last_sec;
      logic rsp_free;
   } status_type;

   // Round half up to Q1.23, then clamp to the 24-bit range.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] sum;
      logic signed [Q_W-1:0]   q;
      logic signed [SAMPLE_W-1:0] res;
      sum = acc + (ACC_W'(1) << (FRAC_SHIFT - 1));
      q   = sum[ACC_W-1:FRAC_SHIFT];
      if (q > Q_W'(SAMPLE_MAX)) begin
         res = SAMPLE_MAX;
      end else if (q < Q_W'(SAMPLE_MIN)) begin
         res = SAMPLE_MIN;
      end else begin
         res = q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/mbq_req_if.sv =====
// ----------------------------------------------------------------------------
// mbq_req_if
// Request channel of the biquad cascade: sample and coefficient items.
// ----------------------------------------------------------------------------
interface mbq_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic                      channel;
   logic signed [23:0]        sample_in;
   logic [1:0]                section_index;
   logic [1:0]                coef_select;
   logic signed [23:0]        coef_value;

   modport source (
      output valid, op, channel, sample_in, section_index, coef_select, coef_value,
      input  ready
   );

   modport sink (
      input  valid, op, channel, sample_in, section_index, coef_select, coef_value,
      output ready
   );
endinterface

// ===== hw/rtl/mbq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mbq_rsp_if
// Response channel of the biquad cascade: one filtered or bypassed sample per beat.
// ----------------------------------------------------------------------------
interface mbq_rsp_if;
   logic               valid;
   logic               ready;
   logic               out_channel;
   logic signed [23:0] sample_out;

   modport source (
      output valid, out_channel, sample_out,
      input  ready
   );

   modport sink (
      input  valid, out_channel, sample_out,
      output ready
   );
endinterface

// ===== hw/rtl/mbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbq_ctrl
// Sequencer of the biquad cascade. Steps the clearing pass, the item handshake,
// four multiply-accumulate steps and write-back per section, and the output.
// ----------------------------------------------------------------------------
module mbq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mbq_pkg::status_type status,
   output mbq_pkg::cmd_type    cmd
);

   mbq_pkg::state_type state_ff;
   mbq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbq_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbq_pkg::ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = mbq_pkg::ST_IDLE;
            end
         end
         mbq_pkg::ST_IDLE: begin
            // Coefficient writes and dropped samples finish in the accept cycle.
            priority if (!req_valid || status.is_coef || !status.ch_ok) begin
               state_in = mbq_pkg::ST_IDLE;
            end else if (status.bypass) begin
               state_in = mbq_pkg::ST_OUT;
            end else begin
               state_in = mbq_pkg::ST_READ;
            end
         end
         mbq_pkg::ST_READ: state_in = mbq_pkg::ST_MUL0;
         mbq_pkg::ST_MUL0: state_in = mbq_pkg::ST_MUL1;
         mbq_pkg::ST_MUL1: state_in = mbq_pkg::ST_MUL2;
         mbq_pkg::ST_MUL2: state_in = mbq_pkg::ST_MUL3;
         mbq_pkg::ST_MUL3: state_in = mbq_pkg::ST_ACC;
         mbq_pkg::ST_ACC:  state_in = mbq_pkg::ST_WB;
         mbq_pkg::ST_WB: begin
            state_in = status.last_sec ? mbq_pkg::ST_OUT : mbq_pkg::ST_MUL0;
         end
         mbq_pkg::ST_OUT: begin
            if (status.rsp_free) begin
               state_in = mbq_pkg::ST_IDLE;
            end
         end
         default: state_in = mbq_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.clr_step = 1'b0;
      cmd.take     = 1'b0;
      cmd.term     = mbq_pkg::TERM_B0X;
      cmd.acc_op   = mbq_pkg::ACC_HOLD;
      cmd.wb       = 1'b0;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         mbq_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         mbq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         mbq_pkg::ST_READ: begin
         end
         mbq_pkg::ST_MUL0: begin
            cmd.term   = mbq_pkg::TERM_B0X;
            cmd.acc_op = mbq_pkg::ACC_CLEAR;
         end
         mbq_pkg::ST_MUL1: begin
            cmd.term   = mbq_pkg::TERM_B0X2;
            cmd.acc_op = mbq_pkg::ACC_ADD;
         end
         mbq_pkg::ST_MUL2: begin
            cmd.term   = mbq_pkg::TERM_A1Y1;
            cmd.acc_op = mbq_pkg::ACC_ADD;
         end
         mbq_pkg::ST_MUL3: begin
            cmd.term   = mbq_pkg::TERM_A2Y2;
            cmd.acc_op = mbq_pkg::ACC_ADD;
         end
         mbq_pkg::ST_ACC: cmd.acc_op = mbq_pkg::ACC_ADD;
         mbq_pkg::ST_WB:  cmd.wb = 1'b1;
         mbq_pkg::ST_OUT: cmd.out_load = status.rsp_free;
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/mbq_dpath.sv =====
// ----------------------------------------------------------------------------
// mbq_dpath
// Datapath of the biquad cascade: coefficient and delay memories, one shared
// multiplier with accumulator, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module mbq_dpath #(
   parameter int NUM_SECTIONS = 4,
   parameter int NUM_CHANNELS = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mbq_pkg::cmd_type           cmd,
   output mbq_pkg::status_type        status,
   input  logic                       req_op,
   input  logic                       req_channel,
   input  logic signed [23:0]         req_sample_in,
   input  logic [1:0]                 req_section_index,
   input  logic [1:0]                 req_coef_select,
   input  logic signed [23:0]         req_coef_value,
   input  logic                       csr_we,
   input  logic                       csr_wdata,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_out_channel,
   output logic signed [23:0]         rsp_sample_out
);

   localparam int ROWS  = NUM_CHANNELS * NUM_SECTIONS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int SW    = mbq_pkg::SAMPLE_W;
   localparam int CW    = mbq_pkg::COEF_W;
   localparam int PW    = mbq_pkg::PROD_W;
   localparam int AW    = mbq_pkg::ACC_W;
   localparam int DW    = mbq_pkg::DLY_W;

   // Delay row layout: {x1, x2, y1, y2}, one row per channel and section.
   logic [DW-1:0]        dly_mem [ROWS];
   logic signed [CW-1:0] b0_mem  [NUM_SECTIONS];
   logic signed [CW-1:0] a1_mem  [NUM_SECTIONS];
   logic signed [CW-1:0] a2_mem  [NUM_SECTIONS];

   logic [DW-1:0]        dly_rd_ff;
   logic signed [CW-1:0] b0_rd_ff;
   logic signed [CW-1:0] a1_rd_ff;
   logic signed [CW-1:0] a2_rd_ff;

   logic                 bypass_ff, bypass_in;
   logic [ROW_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;
   logic                 ch_ff, ch_in;
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ch_ff, rsp_ch_in;
   logic signed [SW-1:0] rsp_sample_ff, rsp_sample_in;

   logic                 last_sec;
   logic                 ch_ok;
   logic                 sec_ok;
   logic                 take_coef;
   logic                 clr_coef;
   logic [ROW_W-1:0]     rd_row;
   logic [SEC_W-1:0]     rd_sec;
   logic signed [SW-1:0] x1, x2, y1, y2;
   logic signed [CW-1:0] mul_a;
   logic signed [SW-1:0] mul_b;
   logic signed [AW-1:0] prod_ext;
   logic signed [SW-1:0] y_new;
   logic [2:0]           coef_we;
   logic [SEC_W-1:0]     coef_waddr;
   logic signed [CW-1:0] coef_wdata;
   logic                 dly_we;
   logic [ROW_W-1:0]     dly_waddr;
   logic [DW-1:0]        dly_wdata;

   assign last_sec  = (sec_ff == SEC_W'(NUM_SECTIONS - 1));
   assign ch_ok     = (32'(req_channel) < NUM_CHANNELS);
   assign sec_ok    = (32'(req_section_index) < NUM_SECTIONS);
   assign take_coef = cmd.take && (req_op == mbq_pkg::OP_COEF) && sec_ok;
   assign clr_coef  = cmd.clr_step && (32'(clr_cnt_ff) < NUM_SECTIONS);

   // During write-back the read port already fetches the next section.
   assign rd_row = (cmd.wb && !last_sec) ? row_ff + 1'b1 : row_ff;
   assign rd_sec = (cmd.wb && !last_sec) ? sec_ff + 1'b1 : sec_ff;

   assign x1 = dly_rd_ff[4*SW-1:3*SW];
   assign x2 = dly_rd_ff[3*SW-1:2*SW];
   assign y1 = dly_rd_ff[2*SW-1:SW];
   assign y2 = dly_rd_ff[SW-1:0];

   always_comb begin
      unique case (cmd.term)
         mbq_pkg::TERM_B0X: begin
            mul_a = b0_rd_ff;
            mul_b = x_ff;
         end
         mbq_pkg::TERM_B0X2: begin
            mul_a = b0_rd_ff;
            mul_b = x2;
         end
         mbq_pkg::TERM_A1Y1: begin
            mul_a = a1_rd_ff;
            mul_b = y1;
         end
         mbq_pkg::TERM_A2Y2: begin
            mul_a = a2_rd_ff;
            mul_b = y2;
         end
         default: begin
            mul_a = b0_rd_ff;
            mul_b = x_ff;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign neg_in   = (cmd.term != mbq_pkg::TERM_B0X);
   assign prod_ext = {{(AW - PW){prod_ff[PW-1]}}, prod_ff};
   assign y_new    = mbq_pkg::round_sat(acc_ff);

   always_comb begin
      unique case (cmd.acc_op)
         mbq_pkg::ACC_CLEAR: acc_in = '0;
         mbq_pkg::ACC_ADD:   acc_in = neg_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
         default:            acc_in = acc_ff;
      endcase
   end

   // Coefficient memory write port: clearing pass or a coefficient item.
   always_comb begin
      coef_waddr = cmd.clr_step ? SEC_W'(clr_cnt_ff) : SEC_W'(req_section_index);
      coef_wdata = cmd.clr_step ? '0 : req_coef_value;
      coef_we[0] = clr_coef || (take_coef && (req_coef_select == mbq_pkg::SEL_B0));
      coef_we[1] = clr_coef || (take_coef && (req_coef_select == mbq_pkg::SEL_A1));
      coef_we[2] = clr_coef || (take_coef && (req_coef_select == mbq_pkg::SEL_A2));
   end

   always_comb begin
      dly_we    = cmd.clr_step || cmd.wb;
      dly_waddr = cmd.clr_step ? clr_cnt_ff : row_ff;
      dly_wdata = cmd.clr_step ? '0 : {x_ff, x1, y_new, y1};
   end

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      dly_rd_ff <= dly_mem[rd_row];
   end

   always_ff @(posedge clock) begin
      if (coef_we[0]) begin
         b0_mem[coef_waddr] <= coef_wdata;
      end
      if (coef_we[1]) begin
         a1_mem[coef_waddr] <= coef_wdata;
      end
      if (coef_we[2]) begin
         a2_mem[coef_waddr] <= coef_wdata;
      end
      b0_rd_ff <= b0_mem[rd_sec];
      a1_rd_ff <= a1_mem[rd_sec];
      a2_rd_ff <= a2_mem[rd_sec];
   end

   always_comb begin
      bypass_in     = csr_we ? csr_wdata : bypass_ff;
      clr_cnt_in    = cmd.clr_step ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      row_in        = row_ff;
      sec_in        = sec_ff;
      ch_in         = ch_ff;
      x_in          = x_ff;
      if (cmd.take) begin
         row_in = req_channel ? ROW_W'(NUM_SECTIONS) : '0;
         sec_in = '0;
         ch_in  = req_channel;
         x_in   = req_sample_in;
      end else if (cmd.wb) begin
         x_in = y_new;
         if (!last_sec) begin
            row_in = row_ff + 1'b1;
            sec_in = sec_ff + 1'b1;
         end
      end
      rsp_valid_in  = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_ch_in     = cmd.out_load ? ch_ff : rsp_ch_ff;
      rsp_sample_in = cmd.out_load ? x_ff : rsp_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff    <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bypass_ff    <= bypass_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      sec_ff        <= sec_in;
      ch_ff         <= ch_in;
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign status.clr_last = (clr_cnt_ff == ROW_W'(ROWS - 1));
   assign status.is_coef  = (req_op == mbq_pkg::OP_COEF);
   assign status.ch_ok    = ch_ok;
   assign status.bypass   = bypass_ff;
   assign status.last_sec = last_sec;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_sample_out  = rsp_sample_ff;

endmodule

// ===== hw/rtl/multichannel_biquad_cascade.sv =====
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade
// Band-pass biquad cascade in direct form I for several channels, sharing one
// 24x24 multiplier over all sections; a sequencer drives the datapath.
// ----------------------------------------------------------------------------
// A filtered sample passes the read state, the multiply, accumulate and write-back
// states of every section and the output state, which waits for a free response;
// a bypassed sample goes from its accept beat straight to the output state. No item
// is taken until the last sample is out, the single multiplier doing four products
// plus accumulate and write-back per section. A coefficient write ends in its accept
// beat. After reset the delay and coefficient memories are cleared, one row a cycle.
module multichannel_biquad_cascade #(
   parameter int NUM_SECTIONS = 4,
   parameter int NUM_CHANNELS = 2
) (
   input  logic      clock,
   input  logic      reset,
   mbq_req_if.sink   req_bus,
   mbq_rsp_if.source rsp_bus,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   mbq_pkg::cmd_type    cmd;
   mbq_pkg::status_type status;

   mbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbq_dpath #(
      .NUM_SECTIONS (NUM_SECTIONS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_bus.op),
      .req_channel       (req_bus.channel),
      .req_sample_in     (req_bus.sample_in),
      .req_section_index (req_bus.section_index),
      .req_coef_select   (req_bus.coef_select),
      .req_coef_value    (req_bus.coef_value),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_out_channel   (rsp_bus.out_channel),
      .rsp_sample_out    (rsp_bus.sample_out)
   );

endmodule

// ===== hw/rtl/mbq_checker.sv =====
// ----------------------------------------------------------------------------
// mbq_checker
// Port-level checks of the biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
module mbq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_op,
   input logic        req_channel,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_sample_out
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // The clearing pass keeps the request side closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // A coefficient beat never creates a response.
   a_coef_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_op == mbq_pkg::OP_COEF) && !rsp_valid) |=> !rsp_valid)
      else $error("response after a coefficient write");

   // A sample beat for channel zero closes the request side in the cycle after it.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_op == mbq_pkg::OP_SAMPLE) && !req_channel) |=> !req_ready)
      else $error("request ready in the cycle after a sample beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_sample_out))
      else $error("response data changed while stalled");

endmodule

bind multichannel_biquad_cascade mbq_checker u_mbq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_op         (req_bus.op),
   .req_channel    (req_bus.channel),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_sample_out (rsp_bus.sample_out)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel biquad cascade. A short table
// covers zero coefficients after reset, extreme coefficients and samples,
// the unused coefficient select and bypass. Random blocks follow, each an
// optional batch of coefficient writes and a burst of mostly samples. Every response
// beat is checked against its table value or a cycle-free bench model of the cascade.
// ----------------------------------------------------------------------------
module tb;

   localparam int NSEC          = 4;
   localparam int NCH           = 2;
   localparam int ITEMS_TOTAL   = 450;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int END_CYCLES    = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_PCT      = 21;

   localparam mbq_pkg::op_type       OP_SAMPLE = mbq_pkg::OP_SAMPLE;
   localparam mbq_pkg::op_type       OP_COEF   = mbq_pkg::OP_COEF;
   localparam mbq_pkg::coef_sel_type SEL_B0    = mbq_pkg::SEL_B0;
   localparam mbq_pkg::coef_sel_type SEL_A1    = mbq_pkg::SEL_A1;
   localparam mbq_pkg::coef_sel_type SEL_A2    = mbq_pkg::SEL_A2;

   localparam logic signed [23:0] SAMPLE_MAX = mbq_pkg::SAMPLE_MAX;
   localparam logic signed [23:0] SAMPLE_MIN = mbq_pkg::SAMPLE_MIN;

   localparam logic [1:0] SEL_UNUSED = 2'd3;

   // Positions of the per-section history words.
   localparam int D_X1 = 0;
   localparam int D_X2 = 1;
   localparam int D_Y1 = 2;
   localparam int D_Y2 = 3;

   typedef logic signed [23:0] q24_type;

   localparam q24_type ONE_Q22 = 24'sh400000;

   typedef struct packed {
      logic    ch;
      q24_type smp;
   } out_beat_type;

   typedef enum logic {
      ROW_ITEM,
      ROW_BYPASS
   } row_kind_type;

   // For a ROW_BYPASS row the ch field carries the new bypass setting.
   typedef struct packed {
      row_kind_type    kind;
      mbq_pkg::op_type op;
      logic            ch;
      q24_type         smp;
      logic [1:0]      sec;
      logic [1:0]      sel;
      q24_type         coef;
      logic            typed;
      q24_type         want;
   } dir_row_type;

   localparam int N_DIR = 23;

   dir_row_type dir_tab [N_DIR] = '{
      // Coefficients are all zero after reset, so every section returns zero.
      '{ROW_ITEM, OP_SAMPLE, 1'b0, SAMPLE_MAX, 2'd0, SEL_B0, 24'sd0, 1'b1, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b1, SAMPLE_MIN, 2'd0, SEL_B0, 24'sd0, 1'b1, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b0, 24'sd0,     2'd0, SEL_B0, 24'sd0, 1'b1, 24'sd0},
      // Extreme coefficients in sections 0 and 3, unity b0 in 1 and 2; unused select.
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd0, SEL_B0,     SAMPLE_MAX,   1'b0, 24'sd0},
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd0, SEL_A1,     SAMPLE_MIN,   1'b0, 24'sd0},
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd0, SEL_A2,     SAMPLE_MAX,   1'b0, 24'sd0},
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd1, SEL_B0,     ONE_Q22,      1'b0, 24'sd0},
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd2, SEL_B0,     ONE_Q22,      1'b0, 24'sd0},
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd3, SEL_B0,     SAMPLE_MIN,   1'b0, 24'sd0},
      '{ROW_ITEM, OP_COEF, 1'b0, 24'sd0, 2'd3, SEL_UNUSED, 24'sh123456,  1'b0, 24'sd0},
      // Full-scale samples drive the first section into saturation.
      '{ROW_ITEM, OP_SAMPLE, 1'b0, SAMPLE_MAX, 2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b0, SAMPLE_MIN, 2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b1, SAMPLE_MAX, 2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b1, -24'sd1,    2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b0, 24'sd1,     2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      // In bypass the sample comes back unchanged.
      '{ROW_BYPASS, OP_SAMPLE, 1'b1, 24'sd0, 2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b0, SAMPLE_MAX,  2'd0, SEL_B0, 24'sd0, 1'b1, SAMPLE_MAX},
      '{ROW_ITEM, OP_SAMPLE, 1'b1, SAMPLE_MIN,  2'd0, SEL_B0, 24'sd0, 1'b1, SAMPLE_MIN},
      '{ROW_ITEM, OP_SAMPLE, 1'b0, 24'sh123456, 2'd0, SEL_B0, 24'sd0, 1'b1, 24'sh123456},
      '{ROW_ITEM, OP_COEF,   1'b0, 24'sd0, 2'd1, SEL_A1, -24'sh200000, 1'b0, 24'sd0},
      // Filtering resumes on the history left before bypass.
      '{ROW_BYPASS, OP_SAMPLE, 1'b0, 24'sd0, 2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b0, 24'sh000100,  2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0},
      '{ROW_ITEM, OP_SAMPLE, 1'b1, -24'sh000100, 2'd0, SEL_B0, 24'sd0, 1'b0, 24'sd0}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   mbq_req_if req_bus ();
   mbq_rsp_if rsp_bus ();

   multichannel_biquad_cascade #(
      .NUM_SECTIONS(NSEC),
      .NUM_CHANNELS(NCH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // Bench copy of the filter state.
   q24_type coef_mem [NSEC][3]     = '{default: '0};
   q24_type dly_mem [NCH][NSEC][4] = '{default: '0};
   logic bypass_mode = 1'b0;

   out_beat_type expected_samples[$];
   int   beats_sent  = 0;
   int   fail_count  = 0;
   int   cycle_count = 0;
   logic hold_req    = 1'b0;
   logic no_idle     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic q24_type round_clamp(longint acc);
      longint r;
      r = (acc + (longint'(1) <<< 21)) >>> 22;
      if (r > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (r < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return q24_type'(r);
   endfunction

   // Runs one sample through all sections of its channel and updates history.
   function automatic q24_type cascade_filter(logic ch, q24_type x_in);
      q24_type x;
      q24_type y;
      longint  acc;
      int      s;
      x = x_in;
      for (s = 0; s < NSEC; s++) begin
         acc = longint'(coef_mem[s][SEL_B0]) * longint'(x)
             - longint'(coef_mem[s][SEL_B0]) * longint'(dly_mem[ch][s][D_X2])
             - longint'(coef_mem[s][SEL_A1]) * longint'(dly_mem[ch][s][D_Y1])
             - longint'(coef_mem[s][SEL_A2]) * longint'(dly_mem[ch][s][D_Y2]);
         y = round_clamp(acc);
         dly_mem[ch][s][D_X2] = dly_mem[ch][s][D_X1];
         dly_mem[ch][s][D_X1] = x;
         dly_mem[ch][s][D_Y2] = dly_mem[ch][s][D_Y1];
         dly_mem[ch][s][D_Y1] = y;
         x = y;
      end
      return x;
   endfunction

   // Mostly moderate values, with full-range and full-scale ones mixed in.
   function automatic q24_type pick_value();
      case ($urandom_range(7))
         0, 1:    return q24_type'($urandom);
         2:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         3, 4, 5: return q24_type'($urandom_range(0, 24'h1FFFFF)) - 24'sh100000;
         default: return q24_type'($urandom_range(0, 24'h1FFF)) - 24'sh1000;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the beat is taken.
   task automatic send_beat(input mbq_pkg::op_type op, input logic ch, input q24_type smp,
                            input logic [1:0] sec, input logic [1:0] sel,
                            input q24_type cv, input logic typed, input q24_type want);
      q24_type filtered;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.op            <= op;
      req_bus.channel       <= ch;
      req_bus.sample_in     <= smp;
      req_bus.section_index <= sec;
      req_bus.coef_select   <= sel;
      req_bus.coef_value    <= cv;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (op == OP_COEF) begin
         if (sel != SEL_UNUSED) coef_mem[sec][sel] = cv;
      end else begin
         filtered = bypass_mode ? smp : cascade_filter(ch, smp);
         expected_samples.push_back(out_beat_type'{ch, typed ? want : filtered});
      end
      beats_sent++;
   endtask

   // Lets the cascade drain completely before the bypass register changes.
   task automatic write_bypass(input logic val);
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= val;
      bypass_mode = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int i;
      int blk;
      int n;
      int k;
      reset                  = 1'b1;
      csr_we                <= 1'b0;
      csr_wdata             <= 1'b0;
      req_bus.valid         <= 1'b0;
      req_bus.op            <= OP_SAMPLE;
      req_bus.channel       <= 1'b0;
      req_bus.sample_in     <= '0;
      req_bus.section_index <= '0;
      req_bus.coef_select   <= SEL_B0;
      req_bus.coef_value    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_bypass(1'b0);
      for (i = 0; i < N_DIR; i++) begin
         if (dir_tab[i].kind == ROW_BYPASS) begin
            write_bypass(dir_tab[i].ch);
         end else begin
            send_beat(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].smp, dir_tab[i].sec,
                      dir_tab[i].sel, dir_tab[i].coef, dir_tab[i].typed, dir_tab[i].want);
         end
      end

      blk = 0;
      while (beats_sent < ITEMS_TOTAL) begin
         blk++;
         if (blk % 8 == 0) write_bypass($urandom_range(3) == 0);
         // The receiver stalls for a long stretch while samples keep coming.
         if (blk == 4) hold_req = 1'b1;
         no_idle = (blk >= 12 && blk < 16);
         if ($urandom_range(3) != 0) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
               send_beat(OP_COEF, 1'($urandom), q24_type'($urandom), 2'($urandom),
                         2'($urandom), pick_value(), 1'b0, 24'sd0);
            end
         end
         n = $urandom_range(4, 24);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0) begin
               send_beat(OP_COEF, 1'($urandom), q24_type'($urandom), 2'($urandom),
                         2'($urandom), pick_value(), 1'b0, 24'sd0);
            end else begin
               send_beat(OP_SAMPLE, 1'($urandom), pick_value(), 2'($urandom),
                         2'($urandom), q24_type'($urandom), 1'b0, 24'sd0);
            end
         end
      end

      req_bus.valid <= 1'b0;
      no_idle = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      out_beat_type exp_beat;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: expected no beat, got %0d", rsp_bus.sample_out);
            fail_count++;
         end else begin
            exp_beat = expected_samples.pop_front();
            if (rsp_bus.out_channel !== exp_beat.ch) begin
               $error("out_channel: expected %0d, got %0d", exp_beat.ch, rsp_bus.out_channel);
               fail_count++;
            end
            if (rsp_bus.sample_out !== exp_beat.smp) begin
               $error("sample_out: expected %0d, got %0d", exp_beat.smp, rsp_bus.sample_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
